// File: rtl/hfus_pkg.sv
// Shared constants, types and the arctangent table for the heading fusion block.
// No dependencies; used by hfus_yaw and imu_odometry_heading_fusion_top.
package hfus_pkg;

    localparam int DEF_CORDIC_STEPS = 14;
    localparam int DEF_ANGLE_BITS   = 16;

    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 168;
    localparam int OP_W        = 2;
    localparam int WEIGHT_W    = 17;
    localparam int CONF_W      = 17;

    localparam logic [OP_W-1:0] OP_IMU  = 2'd0;
    localparam logic [OP_W-1:0] OP_ODOM = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd64225;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [CONF_W-1:0]   CONF_UNSEEN  = 17'd22938;
    localparam logic [CONF_W-1:0]   CONF_ONE     = 17'd65536;

    localparam logic [35:0] PEN_MAX    = 36'd6000;
    localparam logic [13:0] PEN_SCALE  = 14'd10000;
    localparam logic [29:0] CONF_BIAS  = 30'd5000;
    // ceil(2^44 / 10000): exact quotient for numerators below 2^30
    localparam logic signed [31:0] CONF_RECIP = 32'sd1759218605;
    localparam int CONF_SHIFT = 44;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_quat;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/imu_odometry_heading_fusion_top.sv
// IMU or odometry beat: next beat accepted once the serial CORDIC loop in hfus_yaw is
// done, and after ST_BLEND and ST_BWR when a heading blend follows. Publish tick with a
// valid pose: result beat via ST_AGE, ST_PEN, ST_CONF, ST_CQ and ST_PUB, or ST_AGE and
// ST_PUB while a sensor is unseen; hold in publish while the output beat is not taken.
// Reset (synchronous, active low) clears all fusion state, sets imu_weight to 0.98.
// Depends on hfus_pkg and hfus_yaw.
module imu_odometry_heading_fusion_top #(
    parameter int CORDIC_STEPS = hfus_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_BITS   = hfus_pkg::DEF_ANGLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, lin_vel,
    // yaw_rate, stamp_ms
    input  logic [hfus_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation
    input  logic [hfus_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x, out_y, out_heading, out_lin_vel, out_yaw_rate,
    // confidence, zero fill
    output logic [hfus_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hfus_pkg::WEIGHT_W-1:0]       i_cfg_data
);

    localparam int AB = ANGLE_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_YAW   = 4'd1;
    localparam logic [3:0] ST_BLEND = 4'd2;
    localparam logic [3:0] ST_BWR   = 4'd3;
    localparam logic [3:0] ST_AGE   = 4'd4;
    localparam logic [3:0] ST_PEN   = 4'd5;
    localparam logic [3:0] ST_CONF  = 4'd6;
    localparam logic [3:0] ST_CQ    = 4'd7;
    localparam logic [3:0] ST_PUB   = 4'd8;

    logic [3:0]                     r_state;
    logic [hfus_pkg::WEIGHT_W-1:0]  r_imu_weight;
    logic                           r_seen_imu;
    logic                           r_seen_odom;
    logic                           r_pose_valid;
    logic [31:0]                    r_fused_x;
    logic [31:0]                    r_fused_y;
    logic [AB-1:0]                  r_fused_heading;
    logic [AB-1:0]                  r_imu_heading;
    logic [31:0]                    r_last_lin;
    logic [31:0]                    r_last_ang;
    logic [31:0]                    r_imu_time;
    logic [31:0]                    r_odom_time;

    logic [hfus_pkg::OP_W-1:0]      r_op;
    logic [31:0]                    r_pos_x;
    logic [31:0]                    r_pos_y;
    logic [31:0]                    r_lin;
    logic [31:0]                    r_ang;
    logic [31:0]                    r_stamp;
    logic [AB-1:0]                  r_base;
    logic [AB-1:0]                  r_target;
    logic signed [64:0]             r_prod;
    logic [31:0]                    r_age_a;
    logic [31:0]                    r_age_b;
    logic [29:0]                    r_num;
    logic [hfus_pkg::CONF_W-1:0]    r_conf;
    logic                           r_out_valid;
    logic [hfus_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                           w_in_fire;
    logic                           w_yaw_done;
    logic [AB-1:0]                  w_yaw;
    logic [hfus_pkg::WEIGHT_W-1:0]  w_weight;
    logic [AB-1:0]                  w_diff;
    logic signed [31:0]             w_mul_a;
    logic signed [32:0]             w_mul_b;
    logic signed [64:0]             w_mul_p;
    logic signed [64:0]             w_adj;
    logic [32:0]                    w_age_a;
    logic [32:0]                    w_age_b;
    logic [35:0]                    w_pen;
    logic [12:0]                    w_pen_sat;
    logic [13:0]                    w_margin;
    logic [15:0]                    w_heading16;
    logic                           w_out_free;

    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    hfus_yaw #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_fire && (s_axis_tuser == hfus_pkg::OP_IMU
                                || s_axis_tuser == hfus_pkg::OP_ODOM)),
        .i_quat  (hfus_pkg::t_quat'(s_axis_tdata[63:0])),
        .o_done  (w_yaw_done),
        .o_yaw   (w_yaw)
    );

    assign w_weight = (r_imu_weight > hfus_pkg::WEIGHT_ONE) ? hfus_pkg::WEIGHT_ONE
                                                            : r_imu_weight;
    assign w_diff   = r_target - r_base;

    // shared multiplier: heading blend and confidence reciprocal
    always_comb begin
        if (r_state == ST_CONF) begin
            w_mul_a = hfus_pkg::CONF_RECIP;
            w_mul_b = {3'b000, r_num};
        end else begin
            w_mul_a = {15'd0, w_weight};
            w_mul_b = {{(33-AB){w_diff[AB-1]}}, w_diff};
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_adj   = r_prod + 65'sd32768;

    assign w_age_a   = {1'b0, r_stamp} - {1'b0, r_imu_time};
    assign w_age_b   = {1'b0, r_stamp} - {1'b0, r_odom_time};
    assign w_pen     = {2'b00, r_age_a, 2'b00} + {4'd0, r_age_a}
                     + {3'b000, r_age_b, 1'b0} + {4'd0, r_age_b};
    assign w_pen_sat = (w_pen > hfus_pkg::PEN_MAX) ? 13'(hfus_pkg::PEN_MAX) : w_pen[12:0];
    assign w_margin  = hfus_pkg::PEN_SCALE - {1'b0, w_pen_sat};

    if (ANGLE_BITS >= 16) begin : g_hd_top
        assign w_heading16 = r_fused_heading[AB-1 -: 16];
    end else begin : g_hd_low
        assign w_heading16 = {r_fused_heading, {(16-AB){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_weight <= hfus_pkg::WEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_imu_weight <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_seen_imu      <= 1'b0;
            r_seen_odom     <= 1'b0;
            r_pose_valid    <= 1'b0;
            r_fused_x       <= '0;
            r_fused_y       <= '0;
            r_fused_heading <= '0;
            r_imu_heading   <= '0;
            r_last_lin      <= '0;
            r_last_ang      <= '0;
            r_imu_time      <= '0;
            r_odom_time     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != ST_PUB) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        case (s_axis_tuser)
                            hfus_pkg::OP_IMU:  r_state <= ST_YAW;
                            hfus_pkg::OP_ODOM: r_state <= ST_YAW;
                            hfus_pkg::OP_TICK: r_state <= r_pose_valid ? ST_AGE : ST_IDLE;
                            default:           r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_YAW: begin
                    if (w_yaw_done) begin
                        if (r_op == hfus_pkg::OP_IMU) begin
                            r_imu_heading <= w_yaw;
                            r_last_ang    <= r_ang;
                            r_imu_time    <= r_stamp;
                            r_seen_imu    <= 1'b1;
                            r_state       <= r_pose_valid ? ST_BLEND : ST_IDLE;
                        end else begin
                            r_fused_x    <= r_pos_x;
                            r_fused_y    <= r_pos_y;
                            r_last_lin   <= r_lin;
                            r_last_ang   <= r_ang;
                            r_odom_time  <= r_stamp;
                            r_seen_odom  <= 1'b1;
                            r_pose_valid <= 1'b1;
                            if (r_seen_imu) begin
                                r_state <= ST_BLEND;
                            end else begin
                                r_fused_heading <= w_yaw;
                                r_state         <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_BLEND: r_state <= ST_BWR;
                ST_BWR: begin
                    r_fused_heading <= r_base + w_adj[16+AB-1:16];
                    r_state         <= ST_IDLE;
                end
                ST_AGE:  r_state <= (r_seen_imu && r_seen_odom) ? ST_PEN : ST_PUB;
                ST_PEN:  r_state <= ST_CONF;
                ST_CONF: r_state <= ST_CQ;
                ST_CQ:   r_state <= ST_PUB;
                ST_PUB: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op    <= s_axis_tuser;
            r_pos_x <= s_axis_tdata[95:64];
            r_pos_y <= s_axis_tdata[127:96];
            r_lin   <= s_axis_tdata[159:128];
            r_ang   <= s_axis_tdata[191:160];
            r_stamp <= s_axis_tdata[223:192];
        end
        if (r_state == ST_YAW && w_yaw_done) begin
            if (r_op == hfus_pkg::OP_IMU) begin
                r_base   <= r_fused_heading;
                r_target <= w_yaw;
            end else begin
                r_base   <= w_yaw;
                r_target <= r_imu_heading;
            end
        end
        if (r_state == ST_BLEND || r_state == ST_CONF) begin
            r_prod <= w_mul_p;
        end
        if (r_state == ST_AGE) begin
            r_age_a <= w_age_a[32] ? 32'd0 : w_age_a[31:0];
            r_age_b <= w_age_b[32] ? 32'd0 : w_age_b[31:0];
            r_conf  <= hfus_pkg::CONF_UNSEEN;
        end
        if (r_state == ST_PEN) begin
            r_num <= {w_margin, 16'd0} + hfus_pkg::CONF_BIAS;
        end
        if (r_state == ST_CQ) begin
            r_conf <= r_prod[hfus_pkg::CONF_SHIFT + hfus_pkg::CONF_W - 1:hfus_pkg::CONF_SHIFT];
        end
        if (r_state == ST_PUB && w_out_free) begin
            r_out_data <= {7'd0, r_conf, r_last_ang, r_last_lin, w_heading16,
                           r_fused_y, r_fused_x};
        end
    end

`ifndef SYNTHESIS
    a_result_needs_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> r_pose_valid)
        else $error("result beat without a pose");

    a_pose_implies_odom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pose_valid |-> r_seen_odom)
        else $error("pose valid before any odometry");

    a_yaw_done_in_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_yaw_done |-> (r_state == ST_YAW))
        else $error("yaw unit finished outside the yaw wait");

    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[160:144] <= hfus_pkg::CONF_ONE))
        else $error("confidence above one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUB && !w_out_free) |=> (r_state == ST_PUB))
        else $error("publish left while output stalled");
`endif

endmodule

// File: rtl/hfus_yaw.sv
// Quaternion to yaw: one shared 16x16 multiplier for the four products, then a
// CORDIC vectoring loop, one step per cycle. Depends on hfus_pkg.
module hfus_yaw #(
    parameter int CORDIC_STEPS = hfus_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_BITS   = hfus_pkg::DEF_ANGLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  hfus_pkg::t_quat       i_quat,
    output logic                  o_done,
    output logic [ANGLE_BITS-1:0] o_yaw
);

    localparam int IW    = $clog2(CORDIC_STEPS);
    localparam int XW    = 38;
    localparam int SHIFT = 32 - ANGLE_BITS;
    localparam logic [31:0] ROUND_ADD =
        (SHIFT > 0) ? (32'd1 << ((SHIFT > 0) ? SHIFT - 1 : 0)) : 32'd0;
    localparam logic signed [XW-1:0] XS_BASE = {{(XW-29){1'b0}}, 1'b1, 28'd0};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_ITER = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [IW-1:0]           r_cnt;
    hfus_pkg::t_quat         r_quat;
    logic signed [32:0]      r_acc_s;
    logic signed [32:0]      r_acc_c;
    logic signed [XW-1:0]    r_xs;
    logic signed [XW-1:0]    r_ys;
    logic [31:0]             r_z;
    logic                    r_zero;

    logic signed [15:0]      w_ma;
    logic signed [15:0]      w_mb;
    logic signed [31:0]      w_prod;
    logic signed [32:0]      w_prod_ext;
    logic signed [XW-1:0]    w_ys0;
    logic signed [XW-1:0]    w_xs0;
    logic signed [XW-1:0]    w_dx;
    logic signed [XW-1:0]    w_dy;
    logic [31:0]             w_atan;
    logic                    w_ys_pos;
    logic [31:0]             w_zround;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin w_ma = r_quat.w; w_mb = r_quat.z; end
            2'd1:    begin w_ma = r_quat.x; w_mb = r_quat.y; end
            2'd2:    begin w_ma = r_quat.y; w_mb = r_quat.y; end
            default: begin w_ma = r_quat.z; w_mb = r_quat.z; end
        endcase
    end

    assign w_prod     = w_ma * w_mb;
    assign w_prod_ext = {w_prod[31], w_prod};
    assign w_ys0      = {{(XW-33){r_acc_s[32]}}, r_acc_s} <<< 1;
    assign w_xs0      = XS_BASE - ({{(XW-33){r_acc_c[32]}}, r_acc_c} <<< 1);
    assign w_dx       = r_ys >>> r_cnt;
    assign w_dy       = r_xs >>> r_cnt;
    assign w_atan     = hfus_pkg::atan_lookup(5'(r_cnt));
    assign w_ys_pos   = !r_ys[XW-1] && (r_ys != '0);
    assign w_zround   = r_z + ROUND_ADD;

    assign o_done = (r_state == ST_DONE);
    assign o_yaw  = r_zero ? '0 : w_zround[31:SHIFT];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_MUL;
            ST_MUL:  if (r_cnt == IW'(3)) n_state = ST_PREP;
            ST_PREP: n_state = ST_ITER;
            ST_ITER: if (r_cnt == IW'(CORDIC_STEPS - 1)) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_quat  <= i_quat;
                r_cnt   <= '0;
                r_acc_s <= '0;
                r_acc_c <= '0;
            end
            ST_MUL: begin
                if (r_cnt[1]) begin
                    r_acc_c <= r_acc_c + w_prod_ext;
                end else begin
                    r_acc_s <= r_acc_s + w_prod_ext;
                end
                r_cnt <= (r_cnt == IW'(3)) ? '0 : r_cnt + IW'(1);
            end
            ST_PREP: begin
                r_zero <= (w_xs0 == '0) && (w_ys0 == '0);
                if (w_xs0[XW-1]) begin
                    r_xs <= -w_xs0;
                    r_ys <= -w_ys0;
                    r_z  <= 32'h8000_0000;
                end else begin
                    r_xs <= w_xs0;
                    r_ys <= w_ys0;
                    r_z  <= '0;
                end
            end
            ST_ITER: begin
                if (w_ys_pos) begin
                    r_xs <= r_xs + w_dx;
                    r_ys <= r_ys - w_dy;
                    r_z  <= r_z + w_atan;
                end else begin
                    r_xs <= r_xs - w_dx;
                    r_ys <= r_ys + w_dy;
                    r_z  <= r_z - w_atan;
                end
                r_cnt <= r_cnt + IW'(1);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

// File: bench/tb.sv
// Self-checking bench for imu_odometry_heading_fusion_top: beats stream in, poses stream out.
// Carries its own heading-fusion predictor; depends on hfus_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;

    localparam logic [hfus_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int CORDIC_STEPS = hfus_pkg::DEF_CORDIC_STEPS;
    localparam int QUIET_CYCLES = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_PHASES = 6;

    typedef struct {
        logic [hfus_pkg::OP_W-1:0] kind;
        logic signed [15:0]        quat_x, quat_y, quat_z, quat_w;
        logic [31:0]               pos_x, pos_y, lin_vel, ang_vel, stamp;
    } t_sensor_beat;

    typedef struct {
        logic [31:0]                 x, y;
        logic [15:0]                 heading;
        logic [31:0]                 lin_vel, ang_vel;
        logic [hfus_pkg::CONF_W-1:0] conf;
    } t_pose;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [hfus_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [hfus_pkg::OP_W-1:0]        s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [hfus_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [hfus_pkg::WEIGHT_W-1:0]    i_cfg_data = '0;

    t_sensor_beat pending_beats[$];
    t_sensor_beat offered_beat;
    t_pose        expected_poses[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    logic        hold_start = 1'b0;
    int          error_count = 0;
    int          cycle_count = 0;
    logic [31:0] sim_ms = 32'd3000;

    int unsigned send_pct [NUM_PHASES] = '{0, 80, 0, 11, 0, 11};
    int unsigned recv_pct [NUM_PHASES] = '{0, 0, 80, 11, 0, 11};

    // atan(2^-i) in 2^-32 turn
    logic [31:0] atan_turn [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443
    };

    logic [hfus_pkg::WEIGHT_W-1:0] est_weight = hfus_pkg::WEIGHT_RESET;
    logic                est_seen_imu = 1'b0;
    logic                est_seen_odom = 1'b0;
    logic                est_pose_valid = 1'b0;
    logic [31:0]         est_x = '0;
    logic [31:0]         est_y = '0;
    logic [15:0]         est_heading = '0;
    logic [15:0]         est_imu_yaw = '0;
    logic [31:0]         est_lin_vel = '0;
    logic [31:0]         est_ang_vel = '0;
    logic [31:0]         est_imu_stamp = '0;
    logic [31:0]         est_odom_stamp = '0;

    imu_odometry_heading_fusion_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] quat_to_yaw(input t_sensor_beat b);
        longint qx, qy, qz, qw, ys, xs, dx, dy;
        logic [31:0] acc;
        logic [32:0] rounded;
        qx = b.quat_x;
        qy = b.quat_y;
        qz = b.quat_z;
        qw = b.quat_w;
        ys = 2 * (qw * qz + qx * qy);
        xs = 64'sd268435456 - 2 * (qy * qy + qz * qz);
        acc = 32'd0;
        if (xs == 0 && ys == 0) begin
            return 16'd0;
        end
        if (xs < 0) begin
            xs = -xs;
            ys = -ys;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys > 0) begin
                xs += dx;
                ys -= dy;
                acc += atan_turn[i];
            end else begin
                xs -= dx;
                ys += dy;
                acc -= atan_turn[i];
            end
        end
        rounded = {1'b0, acc} + 33'd32768;
        return rounded[31:16];
    endfunction

    function automatic logic [15:0] blend_heading(input logic [15:0] base,
                                                  input logic [15:0] target);
        longint w, d, adj;
        logic [15:0] diff;
        w = (est_weight > hfus_pkg::WEIGHT_ONE) ? 64'sd65536 : longint'(est_weight);
        diff = target - base;
        d = $signed(diff);
        adj = (w * d + 32768) >>> 16;
        return base + adj[15:0];
    endfunction

    function automatic logic [hfus_pkg::CONF_W-1:0] freshness_conf(input logic [31:0] now);
        longint a, b, p, c;
        if (!est_seen_imu || !est_seen_odom) begin
            return hfus_pkg::CONF_UNSEEN;
        end
        a = longint'(now) - longint'(est_imu_stamp);
        b = longint'(now) - longint'(est_odom_stamp);
        if (a < 0) a = 0;
        if (b < 0) b = 0;
        p = 5 * a + 3 * b;
        if (p > 6000) p = 6000;
        c = (65536 * (10000 - p) + 5000) / 10000;
        return c[hfus_pkg::CONF_W-1:0];
    endfunction

    function automatic void fuse_event(input t_sensor_beat b);
        logic [15:0] yaw;
        t_pose pose;
        case (b.kind)
            hfus_pkg::OP_IMU: begin
                est_imu_yaw = quat_to_yaw(b);
                est_ang_vel = b.ang_vel;
                est_imu_stamp = b.stamp;
                est_seen_imu = 1'b1;
                if (est_pose_valid) begin
                    est_heading = blend_heading(est_heading, est_imu_yaw);
                end
            end
            hfus_pkg::OP_ODOM: begin
                yaw = quat_to_yaw(b);
                est_x = b.pos_x;
                est_y = b.pos_y;
                est_lin_vel = b.lin_vel;
                est_ang_vel = b.ang_vel;
                est_odom_stamp = b.stamp;
                est_heading = est_seen_imu ? blend_heading(yaw, est_imu_yaw) : yaw;
                est_seen_odom = 1'b1;
                est_pose_valid = 1'b1;
            end
            hfus_pkg::OP_TICK: begin
                if (est_pose_valid) begin
                    pose.x = est_x;
                    pose.y = est_y;
                    pose.heading = est_heading;
                    pose.lin_vel = est_lin_vel;
                    pose.ang_vel = est_ang_vel;
                    pose.conf = freshness_conf(b.stamp);
                    expected_poses.push_back(pose);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("field %s expected 0x%0h actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic signed [15:0] rand_quat();
        int v;
        if ($urandom_range(15) == 0) begin
            return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        end
        v = int'($urandom_range(32768)) - 16384;
        return v[15:0];
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // driver: hold the beat until accepted, predict on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fuse_event(offered_beat);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_beat = pending_beats.pop_front();
                    s_axis_tdata <= {offered_beat.stamp, offered_beat.ang_vel,
                                     offered_beat.lin_vel, offered_beat.pos_y,
                                     offered_beat.pos_x, offered_beat.quat_w,
                                     offered_beat.quat_z, offered_beat.quat_y,
                                     offered_beat.quat_x};
                    s_axis_tuser <= offered_beat.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: compare each pose beat with the oldest prediction
    always @(posedge i_clk) begin : pose_monitor
        t_pose want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_poses.size() == 0) begin
                    $error("pose beat with no prediction pending");
                    error_count++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("out_x", want.x, m_axis_tdata[31:0]);
                    check_field("out_y", want.y, m_axis_tdata[63:32]);
                    check_field("out_heading", {16'd0, want.heading},
                                {16'd0, m_axis_tdata[79:64]});
                    check_field("out_lin_vel", want.lin_vel, m_axis_tdata[111:80]);
                    check_field("out_yaw_rate", want.ang_vel, m_axis_tdata[143:112]);
                    check_field("confidence", {15'd0, want.conf},
                                {15'd0, m_axis_tdata[160:144]});
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_beat(input logic [hfus_pkg::OP_W-1:0] kind, input int qx,
                             input int qy, input int qz, input int qw,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] lin, input logic [31:0] ang,
                             input logic [31:0] stamp);
        t_sensor_beat b;
        b.kind = kind;
        b.quat_x = qx[15:0];
        b.quat_y = qy[15:0];
        b.quat_z = qz[15:0];
        b.quat_w = qw[15:0];
        b.pos_x = px;
        b.pos_y = py;
        b.lin_vel = lin;
        b.ang_vel = ang;
        b.stamp = stamp;
        pending_beats.push_back(b);
    endtask

    task automatic queue_random_beats(input int count);
        t_sensor_beat b;
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            b.kind = (pick < 38) ? hfus_pkg::OP_IMU : (pick < 62) ? hfus_pkg::OP_ODOM :
                     (pick < 97) ? hfus_pkg::OP_TICK : OP_IGNORED;
            b.quat_x = rand_quat();
            b.quat_y = rand_quat();
            b.quat_z = rand_quat();
            b.quat_w = rand_quat();
            b.pos_x = rand_word();
            b.pos_y = rand_word();
            b.lin_vel = rand_word();
            b.ang_vel = rand_word();
            sim_ms += $urandom_range(40);
            if ($urandom_range(19) == 0) begin
                b.stamp = $urandom();
            end else if (b.kind == hfus_pkg::OP_TICK) begin
                b.stamp = sim_ms + $urandom_range(1200);
            end else begin
                b.stamp = sim_ms - $urandom_range(30);
            end
            pending_beats.push_back(b);
        end
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_poses.size() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [hfus_pkg::WEIGHT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        est_weight = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [hfus_pkg::WEIGHT_W-1:0] weight;
        int unsigned rand_w;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 16384, 0, 0, 0, 0, 100);
        push_beat(OP_IGNORED, -16384, -16384, -16384, -16384, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_beat(hfus_pkg::OP_ODOM, 0, 0, 11585, 11585, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 1000);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1000);
        push_beat(hfus_pkg::OP_IMU, 0, 8192, 8192, 0, 0, 0, 0, 12345, 1000);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1000);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 400);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1500);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_beat(hfus_pkg::OP_IMU, 0, 0, 16384, 0, 0, 0, 0, 32'h8000_0000, 2000);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 2000);
        push_beat(hfus_pkg::OP_IMU, -16384, -16384, -16384, -16384, 0, 0, 0,
                  32'h7FFF_FFFF, 2010);
        push_beat(hfus_pkg::OP_IMU, 16384, 16384, 16384, 16384, 0, 0, 0,
                  32'hFFFF_FFFF, 2020);
        push_beat(hfus_pkg::OP_ODOM, 0, 8192, 8192, 0, 0, 0, 0, 0, 0);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 2030);
        push_beat(hfus_pkg::OP_ODOM, 0, 0, -16384, 0, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_beat(hfus_pkg::OP_IMU, 0, 0, 16384, -16384, 0, 0, 0, 5, 5);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1205);
        push_beat(hfus_pkg::OP_IMU, 16384, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1300);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1300);
        push_beat(hfus_pkg::OP_ODOM, 0, 0, 0, -16384, 32'h1234_5678, 32'h9ABC_DEF0,
                  32'h0001_0000, 32'hFFFF_0000, 1310);
        push_beat(hfus_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1320);
        wait_quiet();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            rand_w = $urandom_range(65536);
            case (ph)
                0: weight = hfus_pkg::WEIGHT_ONE;
                1: weight = '0;
                2: weight = '1;
                3: weight = rand_w[hfus_pkg::WEIGHT_W-1:0];
                4: weight = 17'd32768;
                default: weight = hfus_pkg::WEIGHT_RESET;
            endcase
            write_weight(weight);
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 4) begin
                // stall the output long enough for the input to back up
                @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            queue_random_beats(120);
            wait_quiet();
            queue_random_beats(120);
            wait_quiet();
        end

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/hfus_pkg.sv
rtl/hfus_yaw.sv
rtl/imu_odometry_heading_fusion_top.sv
bench/tb.sv
